// File: src/assert_macros.svh
// assertion macros shared by the decompressor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a named clock and active-low reset
`define MMBD_ASSERT_ON(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
	else $error("mmbd assertion failed");

// concurrent check on the block clock and reset
`define MMBD_ASSERT(lbl, prop) `MMBD_ASSERT_ON(lbl, clk, arst_n, prop)

`endif

// File: src/mmbd_pkg.sv
// types and constants of the multi-mode byte decompressor
`default_nettype none
package mmbd_pkg;

	localparam int unsigned PAT_DEPTH = 15;
	localparam int unsigned PAT_AW    = 4;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QAW       = 2;
	localparam int unsigned SLOTS     = 4;
	localparam int unsigned NCOMMON   = 8;

	localparam logic [7:0] CTRL_ZERO   = 8'hF0;
	localparam logic [7:0] CTRL_PAT    = 8'hE0;
	localparam logic [7:0] CTRL_COMMON = 8'hF2;
	localparam logic [1:0] MODE_LIT    = 2'b00;
	localparam logic [1:0] MODE_NIB    = 2'b01;
	localparam logic [1:0] MODE_RUN    = 2'b10;
	localparam logic [6:0] STEP_BIAS   = 7'd112;

	localparam logic [7:0] COMMON_RESET [NCOMMON] = '{
		8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd255, 8'd127, 8'd32
	};

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_TRUNC = 2'd1,
		ERR_INDEX = 2'd2
	} err_t;

	typedef enum logic [1:0] {PH_CTRL, PH_ARG, PH_ARG2, PH_DATA} phase_t;

	typedef enum logic [2:0] {
		TK_LIT, TK_NIB, TK_RLE, TK_DELTA, TK_ZERO, TK_PAT, TK_COMMON
	} token_t;

	typedef enum logic [2:0] {JB_NONE, JB_RUN, JB_PAIR, JB_RAMP, JB_PAT} job_kind_t;

	typedef enum logic [1:0] {BK_IDLE, BK_GEN, BK_PAT, BK_TAIL} bk_state_t;

	// one request from the front end to the back end
	typedef struct packed {
		job_kind_t         kind;
		logic [7:0]        a;
		logic [7:0]        b;
		logic [PAT_AW-1:0] pat_len;
		logic [PAT_AW-1:0] wr_idx;
		logic [7:0]        count;
		logic              last;
		err_t              err;
	} job_t;

endpackage
`default_nettype wire

// File: src/multi_mode_byte_decompressor.sv
// top level of the multi-mode byte decompressor
// Run-length style decompressor. Compressed bytes arrive one per request on
// the slave stream; decoded bytes leave packed up to four per request on the
// master stream, and no output request carries bytes of two tokens. Tokens:
// 0xF0 zero run, 0xE0 repeated pattern (up to 15 bytes, up to 15 times),
// 0xF2 run of one of eight configurable common values, otherwise the top two
// bits choose literal, nibble-pair unpack, RLE or a ramp taken mod 128.
// A stream that stops inside a token, or a common index of 8 or above, gives
// a zero-byte request carrying the error code. The front end parses one byte
// a cycle into a four-deep request queue and stalls only when that queue is
// full. The back end loads each queued request while idle, then sends one
// output request per cycle for runs, ramps, literals and nibbles while the
// receiver is ready; pattern replays read the pattern store through one port,
// so they run at one decoded byte per cycle, holding when a full word meets
// back-pressure. During a long expansion input is held once the queue fills.
`default_nettype none
module multi_mode_byte_decompressor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // in_byte
	input  wire         s_axis_tlast,   // stream_last
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // out_byte_0..3, byte_count, zero fill
	output logic        m_axis_tlast,   // stream_end
	output logic [2:0]  m_axis_tuser,   // burst_last, error_code
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_idx,
	input  wire  [7:0]  cfg_data
);
	import mmbd_pkg::*;

	// request queue hookup
	job_t            push_job;
	job_t            pop_job;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	// result word from the back end
	logic [3:0][7:0] out_bytes;
	logic [2:0]      out_count;
	logic            out_burst;
	err_t            out_err;

	// parser: classifies each byte and builds a request for the back end
	mmbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.q_full   (full),
		.q_push   (push),
		.q_job    (push_job)
	);

	// decouples parsing from expansion
	mmbd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	// expander with pattern store and registered output word
	mmbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_job     (pop_job),
		.q_pop     (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bytes (out_bytes),
		.out_count (out_count),
		.out_burst (out_burst),
		.out_end   (m_axis_tlast),
		.out_err   (out_err)
	);

	// unused slots are already zero from the back end
	assign m_axis_tdata = {5'd0, out_count, out_bytes};
	assign m_axis_tuser = {out_err, out_burst};

endmodule
`default_nettype wire

// File: src/mmbd_front.sv
// front end: token parser, common-value registers and request builder
`default_nettype none
module mmbd_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [7:0]       in_byte,
	input  wire              in_last,
	input  wire              cfg_we,
	input  wire  [2:0]       cfg_idx,
	input  wire  [7:0]       cfg_data,
	input  wire              q_full,
	output logic             q_push,
	output mmbd_pkg::job_t   q_job
);
	import mmbd_pkg::*;

	phase_t      ph_q, ph_d;
	token_t      tk_q, tk_d;
	logic [5:0]  rem_q, rem_d;
	logic [3:0]  plen_q, plen_d;
	logic [3:0]  rep_q, rep_d;
	logic [3:0]  fill_q, fill_d;
	logic [6:0]  ramp_q, ramp_d;
	logic        odd_q, odd_d;
	logic [7:0]  cv_q [NCOMMON];
	logic        accept;
	logic [5:0]  len;
	logic [6:0]  nib_sum;
	logic [5:0]  rem_dec;
	job_t        job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign len      = in_byte[5:0];
	assign nib_sum  = {1'b0, len} + 7'd1;
	assign rem_dec  = (rem_q != 6'd0) ? rem_q - 6'd1 : 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_CTRL;
			tk_q   <= TK_LIT;
			rem_q  <= '0;
			plen_q <= '0;
			rep_q  <= '0;
			fill_q <= '0;
			ramp_q <= '0;
			odd_q  <= 1'b0;
		end else if (accept) begin
			ph_q   <= ph_d;
			tk_q   <= tk_d;
			rem_q  <= rem_d;
			plen_q <= plen_d;
			rep_q  <= rep_d;
			fill_q <= fill_d;
			ramp_q <= ramp_d;
			odd_q  <= odd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= COMMON_RESET;
		end else if (cfg_we) begin
			cv_q[cfg_idx] <= cfg_data;
		end
	end

	always_comb begin
		ph_d   = ph_q;
		tk_d   = tk_q;
		rem_d  = rem_q;
		plen_d = plen_q;
		rep_d  = rep_q;
		fill_d = fill_q;
		ramp_d = ramp_q;
		odd_d  = odd_q;
		job.kind    = JB_NONE;
		job.a       = '0;
		job.b       = '0;
		job.pat_len = plen_q;
		job.wr_idx  = fill_q;
		job.count   = '0;
		job.last    = in_last;
		job.err     = ERR_OK;
		unique case (ph_q)
			PH_CTRL: begin
				priority if (in_byte == CTRL_ZERO) begin
					tk_d = TK_ZERO;
					ph_d = PH_ARG;
				end else if (in_byte == CTRL_PAT) begin
					tk_d = TK_PAT;
					ph_d = PH_ARG;
				end else if (in_byte == CTRL_COMMON) begin
					tk_d = TK_COMMON;
					ph_d = PH_ARG;
				end else if (in_byte[7:6] == MODE_RUN) begin
					tk_d  = TK_RLE;
					rem_d = len;
					ph_d  = PH_ARG;
				end else if (in_byte[7:6] == MODE_NIB) begin
					tk_d  = TK_NIB;
					rem_d = nib_sum[6:1];
					odd_d = len[0];
					ph_d  = (nib_sum[6:1] != 6'd0) ? PH_DATA : PH_CTRL;
				end else if (in_byte[7:6] == MODE_LIT) begin
					tk_d  = TK_LIT;
					rem_d = len;
					ph_d  = (len != 6'd0) ? PH_DATA : PH_CTRL;
				end else begin
					tk_d  = TK_DELTA;
					rem_d = len;
					ph_d  = PH_ARG;
				end
			end
			PH_ARG: begin
				ph_d = PH_CTRL;
				unique case (tk_q)
					TK_ZERO: begin
						job.kind  = JB_RUN;
						job.count = in_byte;
					end
					TK_PAT: begin
						plen_d = in_byte[7:4];
						rep_d  = in_byte[3:0];
						fill_d = '0;
						if (in_byte[7:4] != 4'd0) ph_d = PH_DATA;
					end
					TK_COMMON: begin
						if (in_byte[3]) begin
							job.err = ERR_INDEX;
						end else begin
							job.kind  = JB_RUN;
							job.a     = cv_q[in_byte[2:0]];
							job.count = {4'd0, in_byte[7:4]};
						end
					end
					TK_RLE: begin
						job.kind  = JB_RUN;
						job.a     = in_byte;
						job.count = {2'd0, rem_q};
						rem_d     = '0;
					end
					TK_DELTA: begin
						ramp_d = in_byte[6:0];
						ph_d   = PH_ARG2;
					end
					default: ;
				endcase
			end
			PH_ARG2: begin
				job.kind  = JB_RAMP;
				job.a     = {1'b0, ramp_q};
				job.b     = {1'b0, in_byte[6:0] + STEP_BIAS};
				job.count = {2'd0, rem_q};
				rem_d     = '0;
				ph_d      = PH_CTRL;
			end
			PH_DATA: begin
				unique case (tk_q)
					TK_LIT: begin
						job.kind  = JB_PAIR;
						job.a     = in_byte;
						job.count = 8'd1;
						rem_d     = rem_dec;
						if (rem_dec == 6'd0) ph_d = PH_CTRL;
					end
					TK_NIB: begin
						job.kind  = JB_PAIR;
						job.a     = {4'd0, in_byte[7:4]};
						job.b     = {4'd0, in_byte[3:0]};
						job.count = (rem_q == 6'd1 && odd_q) ? 8'd1 : 8'd2;
						rem_d     = rem_dec;
						if (rem_dec == 6'd0) begin
							odd_d = 1'b0;
							ph_d  = PH_CTRL;
						end
					end
					TK_PAT: begin
						job.kind = JB_PAT;
						job.a    = in_byte;
						fill_d   = fill_q + 4'd1;
						if (fill_d >= plen_q) begin
							job.count = {4'd0, plen_q} * {4'd0, rep_q};
							ph_d      = PH_CTRL;
						end
					end
					default: ph_d = PH_CTRL;
				endcase
			end
			default: ph_d = PH_CTRL;
		endcase
		if (in_last) begin
			if (ph_d != PH_CTRL) job.err = ERR_TRUNC;
			ph_d   = PH_CTRL;
			tk_d   = TK_LIT;
			rem_d  = '0;
			plen_d = '0;
			rep_d  = '0;
			fill_d = '0;
			ramp_d = '0;
			odd_d  = 1'b0;
		end
	end

	assign q_job  = job;
	assign q_push = accept && (job.count != 8'd0 || in_last || job.err != ERR_OK ||
		job.kind == JB_PAT);

endmodule
`default_nettype wire

// File: src/mmbd_fifo.sv
// request queue between front end and back end
`default_nettype none
`include "assert_macros.svh"
module mmbd_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  mmbd_pkg::job_t  push_job,
	output logic            full,
	input  wire             pop,
	output mmbd_pkg::job_t  pop_job,
	output logic            empty
);
	import mmbd_pkg::*;

	job_t           entries_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign full    = cnt_q == (QAW+1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign pop_job = entries_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`MMBD_ASSERT(a_no_overflow, !(push && full && !pop))
	`MMBD_ASSERT(a_no_underflow, !(pop && empty))
	`MMBD_ASSERT(a_cnt_bound, cnt_q <= (QAW+1)'(QDEPTH))

endmodule
`default_nettype wire

// File: src/mmbd_back.sv
// back end: expands queued requests into packed result words
`default_nettype none
`include "assert_macros.svh"
module mmbd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_empty,
	input  mmbd_pkg::job_t       q_job,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [3:0][7:0]      out_bytes,
	output logic [2:0]           out_count,
	output logic                 out_burst,
	output logic                 out_end,
	output mmbd_pkg::err_t       out_err
);
	import mmbd_pkg::*;

	bk_state_t   st_q, st_d;
	job_t        job_q, job_d;
	logic [7:0]  rem_q, rem_d;
	logic [6:0]  ramp_q, ramp_d;
	logic [3:0]  pidx_q, pidx_d;
	logic [7:0]  pk_q [3];
	logic [7:0]  pk_d [3];
	logic [1:0]  pkn_q, pkn_d;
	logic [7:0]  store_q [PAT_DEPTH];

	logic            ovalid_q;
	logic [3:0][7:0] ob_q, ob_d;
	logic [2:0]      ocnt_q, ocnt_d;
	logic            oburst_q, oburst_d;
	logic            oend_q, oend_d;
	err_t            oerr_q, oerr_d;
	logic            load;
	logic            slot_free;
	logic [2:0]      n;
	logic [6:0]      step;
	logic [6:0]      rv [SLOTS];
	logic [7:0]      pbyte;
	logic            pemit;

	assign slot_free = !ovalid_q || out_ready;
	assign n         = (rem_q > 8'd4) ? 3'd4 : rem_q[2:0];
	assign step      = job_q.b[6:0];
	assign pbyte     = store_q[pidx_q];
	assign pemit     = (pkn_q == 2'd3) || (rem_q == 8'd1);

	always_comb begin
		rv[0] = ramp_q;
		for (int k = 1; k < SLOTS; k++) rv[k] = rv[k-1] + step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		q_pop    = 1'b0;
		load     = 1'b0;
		job_d    = job_q;
		rem_d    = rem_q;
		ramp_d   = ramp_q;
		pidx_d   = pidx_q;
		pk_d     = pk_q;
		pkn_d    = pkn_q;
		ob_d     = '0;
		ocnt_d   = '0;
		oburst_d = 1'b0;
		oend_d   = 1'b0;
		oerr_d   = ERR_OK;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					job_d  = q_job;
					rem_d  = q_job.count;
					ramp_d = q_job.a[6:0];
					pidx_d = '0;
					pkn_d  = '0;
					if (q_job.count != 8'd0)
						st_d = (q_job.kind == JB_PAT) ? BK_PAT : BK_GEN;
					else if (q_job.err != ERR_OK || q_job.last)
						st_d = BK_TAIL;
				end
			end
			BK_GEN: begin
				if (slot_free) begin
					load = 1'b1;
					for (int k = 0; k < SLOTS; k++) begin
						if (3'(k) < n) begin
							unique case (job_q.kind)
								JB_RAMP: ob_d[k] = {1'b0, rv[k]};
								JB_PAIR: ob_d[k] = (k == 0) ? job_q.a : job_q.b;
								default: ob_d[k] = job_q.a;
							endcase
						end
					end
					ocnt_d = n;
					rem_d  = rem_q - {5'd0, n};
					ramp_d = ramp_q + {step[4:0], 2'b00};
					if (rem_q == {5'd0, n}) begin
						oburst_d = job_q.err == ERR_OK;
						oend_d   = job_q.last && job_q.err == ERR_OK;
						st_d     = (job_q.err != ERR_OK) ? BK_TAIL : BK_IDLE;
					end
				end
			end
			BK_PAT: begin
				if (!pemit || slot_free) begin
					pidx_d = (pidx_q == job_q.pat_len - 4'd1) ? 4'd0 : pidx_q + 4'd1;
					rem_d  = rem_q - 8'd1;
					if (pemit) begin
						load = 1'b1;
						for (int k = 0; k < SLOTS; k++) begin
							if (2'(k) < pkn_q && k < 3) ob_d[k] = pk_q[k];
							else if (2'(k) == pkn_q && k < 3) ob_d[k] = pbyte;
						end
						if (pkn_q == 2'd3) ob_d[3] = pbyte;
						ocnt_d = {1'b0, pkn_q} + 3'd1;
						pkn_d  = '0;
						if (rem_q == 8'd1) begin
							oburst_d = job_q.err == ERR_OK;
							oend_d   = job_q.last && job_q.err == ERR_OK;
							st_d     = (job_q.err != ERR_OK) ? BK_TAIL : BK_IDLE;
						end
					end else begin
						pk_d[pkn_q] = pbyte;
						pkn_d       = pkn_q + 2'd1;
					end
				end
			end
			BK_TAIL: begin
				if (slot_free) begin
					load     = 1'b1;
					oburst_d = 1'b1;
					oend_d   = job_q.last;
					oerr_d   = job_q.err;
					st_d     = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		job_q  <= job_d;
		rem_q  <= rem_d;
		ramp_q <= ramp_d;
		pidx_q <= pidx_d;
		pk_q   <= pk_d;
		pkn_q  <= pkn_d;
		if (q_pop && q_job.kind == JB_PAT && q_job.wr_idx != 4'(PAT_DEPTH))
			store_q[q_job.wr_idx] <= q_job.a;
		if (load) begin
			ob_q     <= ob_d;
			ocnt_q   <= ocnt_d;
			oburst_q <= oburst_d;
			oend_q   <= oend_d;
			oerr_q   <= oerr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;
	assign out_bytes = ob_q;
	assign out_count = ocnt_q;
	assign out_burst = oburst_q;
	assign out_end   = oend_q;
	assign out_err   = oerr_q;

	`MMBD_ASSERT(a_empty_word_flagged,
		(ovalid_q && ocnt_q == 3'd0) |-> (oerr_q != ERR_OK || oend_q))
	`MMBD_ASSERT(a_end_closes_burst, (ovalid_q && oend_q) |-> oburst_q)
	`MMBD_ASSERT(a_pat_index_in_range,
		(st_q == BK_PAT) |-> (job_q.pat_len != 4'd0 && pidx_q < job_q.pat_len))

endmodule
`default_nettype wire

// File: bench/tb_multi_mode_byte_decompressor.sv
// testbench of the multi-mode byte decompressor: stream stimulus, predicted results, field checks
`timescale 1ns / 1ps
`default_nettype none
module tb_multi_mode_byte_decompressor;
	import mmbd_pkg::*;

	// one decoded output request
	typedef struct {
		logic [7:0] b [4];
		logic [2:0] cnt;
		logic       burst_last;
		logic       stream_end;
		logic [1:0] err;
	} beat_t;

	// expected output requests and their checking
	class beat_board;
		beat_t pending [$];
		int    mismatches;
		int    extra;

		function void note(beat_t e);
			pending.push_back(e);
		endfunction

		function void check(beat_t got);
			beat_t e;
			bit    bad;
			if (pending.size() == 0) begin
				extra++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output request cnt=%0d err=%0d", got.cnt, got.err);
				return;
			end
			e = pending.pop_front();
			bad = (e.cnt != got.cnt) || (e.burst_last != got.burst_last) ||
				(e.stream_end != got.stream_end) || (e.err != got.err);
			for (int j = 0; j < 4; j++)
				if (e.b[j] != got.b[j]) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp %h %h %h %h cnt=%0d bl=%0d se=%0d err=%0d",
						e.b[0], e.b[1], e.b[2], e.b[3], e.cnt, e.burst_last,
						e.stream_end, e.err);
					$display("          got %h %h %h %h cnt=%0d bl=%0d se=%0d err=%0d",
						got.b[0], got.b[1], got.b[2], got.b[3],
						got.cnt, got.burst_last, got.stream_end, got.err);
				end
			end
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       s_axis_tvalid = 0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic       s_axis_tlast = 0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 0;
	logic [39:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [2:0] m_axis_tuser;
	logic       cfg_we = 0;
	logic [2:0] cfg_idx = 0;
	logic [7:0] cfg_data = 0;

	multi_mode_byte_decompressor dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	beat_board board = new();

	// predictor state, kept apart from the block
	logic [7:0] common_vals [8];
	phase_t     ph;
	token_t     kind;
	int unsigned remaining, pat_len, reps, fill;
	logic [7:0] pat [15];
	logic [7:0] ramp0;
	bit         odd_pending;

	int  send_idle_pct, recv_stall_pct;
	int  idle_cycles = 0;

	function automatic void clear_token();
		ph = PH_CTRL; kind = TK_LIT; remaining = 0; pat_len = 0; reps = 0;
		fill = 0; ramp0 = 0; odd_pending = 0;
	endfunction

	// expand one compressed byte into expected output requests
	function automatic void decode_byte(logic [7:0] b, bit last);
		logic [7:0] outq [$];
		int unsigned err = 0, k = 0, cnt;
		logic [6:0] stp;
		beat_t e;
		case (ph)
			PH_CTRL: begin
				if (b == CTRL_ZERO) begin kind = TK_ZERO; ph = PH_ARG; end
				else if (b == CTRL_PAT) begin kind = TK_PAT; ph = PH_ARG; end
				else if (b == CTRL_COMMON) begin kind = TK_COMMON; ph = PH_ARG; end
				else if (b[7:6] == MODE_RUN) begin
					kind = TK_RLE; remaining = b[5:0]; ph = PH_ARG;
				end else if (b[7:6] == MODE_NIB) begin
					kind = TK_NIB; remaining = (b[5:0] + 1) / 2; odd_pending = b[0];
					ph = remaining ? PH_DATA : PH_CTRL;
				end else if (b[7:6] == MODE_LIT) begin
					kind = TK_LIT; remaining = b[5:0];
					ph = remaining ? PH_DATA : PH_CTRL;
				end else begin
					kind = TK_DELTA; remaining = b[5:0]; ph = PH_ARG;
				end
			end
			PH_ARG: begin
				ph = PH_CTRL;
				case (kind)
					TK_ZERO: for (int i = 0; i < b; i++) outq.push_back(8'h00);
					TK_PAT: begin
						pat_len = b[7:4]; reps = b[3:0]; fill = 0;
						if (pat_len != 0) ph = PH_DATA;
					end
					TK_COMMON: begin
						if (b[3:0] >= NCOMMON) err = ERR_INDEX;
						else for (int i = 0; i < b[7:4]; i++) outq.push_back(common_vals[b[2:0]]);
					end
					TK_RLE: begin
						for (int i = 0; i < remaining; i++) outq.push_back(b);
						remaining = 0;
					end
					TK_DELTA: begin ramp0 = b; ph = PH_ARG2; end
					default: ;
				endcase
			end
			PH_ARG2: begin
				stp = b[6:0] + STEP_BIAS;
				for (int i = 0; i < remaining; i++)
					outq.push_back({1'b0, 7'(ramp0[6:0] + 7'(i) * stp)});
				remaining = 0;
				ph = PH_CTRL;
			end
			PH_DATA: begin
				if (kind == TK_LIT) begin
					outq.push_back(b);
					remaining--;
					if (remaining == 0) ph = PH_CTRL;
				end else if (kind == TK_NIB) begin
					outq.push_back({4'h0, b[7:4]});
					if (!(remaining == 1 && odd_pending)) outq.push_back({4'h0, b[3:0]});
					remaining--;
					if (remaining == 0) begin odd_pending = 0; ph = PH_CTRL; end
				end else begin
					pat[fill] = b;
					fill++;
					if (fill >= pat_len) begin
						for (int r = 0; r < reps; r++)
							for (int i = 0; i < pat_len; i++) outq.push_back(pat[i]);
						ph = PH_CTRL;
					end
				end
			end
		endcase
		if (last) begin
			if (ph != PH_CTRL) err = ERR_TRUNC;
			clear_token();
		end
		// pack up to four bytes per request; the last data request may carry the end flags
		while (outq.size() > 0) begin
			cnt = outq.size() > 4 ? 4 : outq.size();
			for (int j = 0; j < 4; j++) e.b[j] = (j < cnt) ? outq[j] : 8'h00;
			repeat (cnt) void'(outq.pop_front());
			e.cnt = 3'(cnt); e.err = ERR_OK; e.stream_end = 0;
			e.burst_last = (outq.size() == 0) && !(err != 0 || (last && 0));
			if (outq.size() == 0 && err == 0 && last) e.stream_end = 1;
			board.note(e);
			k++;
		end
		if (err != 0 || (last && k == 0)) begin
			// a data request before an error request is no longer the burst's last
			for (int j = 0; j < 4; j++) e.b[j] = 8'h00;
			e.cnt = 0; e.err = 2'(err); e.stream_end = last; e.burst_last = 1;
			if (k > 0) board.pending[board.pending.size() - 1].burst_last = 0;
			board.note(e);
		end
	endfunction

	// send one compressed byte, idling first at the current rate
	task automatic send_byte(logic [7:0] b, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		decode_byte(b, last);
	endtask

	// hold the sender until every expected request has come
	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [7:0] v);
		cfg_we <= 1; cfg_idx <= idx[2:0]; cfg_data <= v;
		@(posedge clk);
		common_vals[idx] = v;
	endtask

	// a complete token with random content, sometimes with a bad common index
	task automatic random_token();
		int sel = $urandom_range(7);
		int n;
		case (sel)
			0: begin n = $urandom_range(12); send_byte({2'b00, 6'(n)}, 0);
				repeat (n) send_byte(8'($urandom), 0); end
			1: begin n = $urandom_range(12); send_byte({2'b01, 6'(n)}, 0);
				repeat ((n + 1) / 2) send_byte(8'($urandom), 0); end
			2: begin send_byte({2'b10, 6'($urandom_range(63))}, 0);
				send_byte(8'($urandom), 0); end
			3: begin
				do n = $urandom_range(8'hC0, 8'hFF); while (n == 8'hE0 || n == 8'hF0 || n == 8'hF2);
				send_byte(8'(n), 0); send_byte(8'($urandom), 0); send_byte(8'($urandom), 0);
			end
			4: begin send_byte(CTRL_ZERO, 0); send_byte(8'($urandom_range(40)), 0); end
			5: begin
				n = $urandom_range(6);
				send_byte(CTRL_PAT, 0);
				send_byte({4'(n), 4'($urandom_range(15))}, 0);
				repeat (n) send_byte(8'($urandom), 0);
			end
			default: begin send_byte(CTRL_COMMON, 0);
				send_byte({4'($urandom_range(15)), 4'($urandom_range(9) < 8 ? $urandom_range(7) :
					$urandom_range(8, 15))}, 0); end
		endcase
	endtask

	// receiver: random back-pressure and checking
	always @(posedge clk) begin
		beat_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				for (int j = 0; j < 4; j++) got.b[j] = m_axis_tdata[8*j +: 8];
				got.cnt = m_axis_tdata[34:32];
				got.stream_end = m_axis_tlast;
				got.burst_last = m_axis_tuser[0];
				got.err = m_axis_tuser[2:1];
				board.check(got);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[multi_mode_byte_decompressor] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		send_idle_pct = 0; recv_stall_pct = 0;
		for (int i = 0; i < 8; i++) common_vals[i] = COMMON_RESET[i];
		clear_token();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every token kind, the extremes and the special cases
		write_reg(0, 8'h00); write_reg(7, 8'hFF);
		cfg_we <= 0;
		send_byte(8'h02, 0); send_byte(8'hFF, 0); send_byte(8'h00, 0);   // literal
		send_byte(8'h43, 0); send_byte(8'hAB, 0); send_byte(8'hCD, 0);   // odd nibble count
		send_byte(8'hBF, 0); send_byte(8'h5A, 0);                        // long rle
		send_byte(8'hFF, 0); send_byte(8'h7F, 0); send_byte(8'h00, 0);   // ramp
		send_byte(8'hF1, 0); send_byte(8'h80, 0); send_byte(8'hFF, 0);   // 0xF1 as ramp
		send_byte(CTRL_ZERO, 0); send_byte(8'h00, 0);                    // zero-length run
		send_byte(CTRL_PAT, 0); send_byte(8'h0F, 0);                     // empty pattern
		send_byte(CTRL_COMMON, 0); send_byte(8'hF7, 0);
		send_byte(CTRL_COMMON, 0); send_byte(8'h3F, 0);                  // bad index
		send_byte(8'h00, 1);                                             // plain end
		send_byte(CTRL_PAT, 0); send_byte(8'hFF, 0);
		repeat (15) send_byte(8'($urandom), 0);                          // longest replay
		send_byte(CTRL_ZERO, 0); send_byte(8'hFF, 1);                    // end on data
		send_byte(8'h85, 1);                                             // truncated token
		drain();

		// random phases with varying idling and register settings
		sent = 0;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			for (int i = 0; i < 8; i++)
				write_reg(i, p == 1 ? 8'h00 : p == 2 ? 8'hFF : 8'($urandom));
			cfg_we <= 0;
			repeat (12) begin
				if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'($urandom_range(1)));
				else random_token();
				if ($urandom_range(5) == 0) send_byte(8'($urandom), 1);
			end
			send_byte(8'($urandom), 1);
			drain();
		end

		send_idle_pct = 0; recv_stall_pct = 0;
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("[multi_mode_byte_decompressor] OK");
		end else begin
			$display("[multi_mode_byte_decompressor] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
